// File: src/msa_rle_pkg.sv
// Shared types and constants for the run-length floppy image decoder.
// No dependencies; imported by every module of the block.
package msa_rle_pkg;

    localparam int SECTOR_BYTES_DEF = 512;
    localparam int POS_W            = 33;
    localparam int LEN_W            = 16;

    localparam logic [7:0] MARK_BYTE = 8'hE5;
    localparam logic [7:0] SIG_BYTE0 = 8'h0E;
    localparam logic [7:0] SIG_BYTE1 = 8'h0F;

    typedef enum logic [1:0] {
        KIND_RUN    = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_BADSIG = 2'd3
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  lat_run_byte;
        logic  lat_spt;
        logic  lat_side;
        logic  lat_count_high;
        logic  lat_tracks;
        logic  cap_step1;
        logic  cap_step2;
        logic  load_bytes;
        logic  dec_bytes;
        logic  advance_pos;
        logic  dec_tracks;
        logic  marker_run;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sig_ok;
        logic is_mark;
        logic word_zero;
        logic word_raw;
        logic overflow;
        logic bytes_last;
        logic bytes_short;
        logic tracks_last;
        logic tracks_zero;
        logic out_free;
    } status_t;

endpackage

// File: src/msa_rle_ctrl.sv
// Parse controller: header, track length and token state machine.
// Depends on msa_rle_pkg; drives msa_rle_dp through cmd_t, reads status_t.
module msa_rle_ctrl
    import msa_rle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    start_of_file,
    input  status_t sts,
    output logic    in_ready,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HEADER,
        PH_CAP1,
        PH_CAP2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_RAW,
        PH_TOKEN,
        PH_MVAL,
        PH_MCNT_HI,
        PH_MCNT_LO
    } phase_t;

    localparam logic [3:0] HDR_SIG0   = 4'd0;
    localparam logic [3:0] HDR_SIG1   = 4'd1;
    localparam logic [3:0] HDR_SPT    = 4'd3;
    localparam logic [3:0] HDR_SIDES  = 4'd5;
    localparam logic [3:0] HDR_TRK_HI = 4'd8;
    localparam logic [3:0] HDR_TRK_LO = 4'd9;

    phase_t     phase_reg, phase_next, eff_phase;
    logic [3:0] header_index_reg, header_index_next, eff_index;
    logic       track_is_raw_reg, track_is_raw_next;
    logic       busy, accept, do_run, done;

    always_comb
    begin
        cmd               = '0;
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        track_is_raw_next = track_is_raw_reg;
        do_run            = 1'b0;
        done              = 1'b0;

        busy      = (phase_reg == PH_CAP1) || (phase_reg == PH_CAP2);
        in_ready  = sts.out_free && !busy;
        accept    = in_valid && in_ready;
        eff_phase = start_of_file ? PH_HEADER : phase_reg;
        eff_index = start_of_file ? 4'd0 : header_index_reg;
        cmd.marker_run = (phase_reg == PH_MCNT_LO);

        if (busy)
        begin
            if (phase_reg == PH_CAP1)
            begin
                cmd.cap_step1 = 1'b1;
                phase_next    = PH_CAP2;
            end
            else
            begin
                cmd.cap_step2 = 1'b1;
                if (sts.tracks_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DONE;
                    cmd.emit_last = 1'b1;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
        end
        else if (accept)
        begin
            case (eff_phase)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_HEADER:
                begin
                    phase_next        = PH_HEADER;
                    header_index_next = eff_index + 4'd1;
                    case (eff_index)
                        HDR_SIG0:   cmd.lat_run_byte = 1'b1;
                        HDR_SIG1:
                        begin
                            if (!sts.sig_ok)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_BADSIG;
                                cmd.emit_last = 1'b1;
                                phase_next    = PH_IDLE;
                            end
                        end
                        HDR_SPT:    cmd.lat_spt = 1'b1;
                        HDR_SIDES:  cmd.lat_side = 1'b1;
                        HDR_TRK_HI: cmd.lat_count_high = 1'b1;
                        HDR_TRK_LO:
                        begin
                            cmd.lat_tracks    = 1'b1;
                            header_index_next = eff_index;
                            phase_next        = PH_CAP1;
                        end
                        default: ;
                    endcase
                end
                PH_LEN_HI:
                begin
                    cmd.lat_count_high = 1'b1;
                    phase_next         = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    cmd.load_bytes    = 1'b1;
                    track_is_raw_next = sts.word_raw;
                    if (sts.word_zero)
                    begin
                        // empty track ends at once
                        cmd.dec_tracks = 1'b1;
                        if (sts.tracks_last)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_DONE;
                            cmd.emit_last = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                    else
                    begin
                        phase_next = sts.word_raw ? PH_RAW : PH_TOKEN;
                    end
                end
                PH_RAW:
                begin
                    cmd.dec_bytes = 1'b1;
                    do_run        = 1'b1;
                end
                PH_TOKEN:
                begin
                    cmd.dec_bytes = 1'b1;
                    if (!sts.is_mark)
                    begin
                        do_run = 1'b1;
                    end
                    else if (sts.bytes_short)
                    begin
                        // marker cut off by end of track
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_ERROR;
                        cmd.emit_last = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_MVAL;
                    end
                end
                PH_MVAL:
                begin
                    cmd.dec_bytes    = 1'b1;
                    cmd.lat_run_byte = 1'b1;
                    phase_next       = PH_MCNT_HI;
                end
                PH_MCNT_HI:
                begin
                    cmd.dec_bytes      = 1'b1;
                    cmd.lat_count_high = 1'b1;
                    phase_next         = PH_MCNT_LO;
                end
                PH_MCNT_LO:
                begin
                    cmd.dec_bytes = 1'b1;
                    do_run        = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_run)
            begin
                if (sts.overflow)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ERROR;
                    cmd.emit_last = 1'b1;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    cmd.advance_pos = 1'b1;
                    done            = sts.bytes_last && sts.tracks_last;
                    if (sts.bytes_last)
                    begin
                        cmd.dec_tracks = 1'b1;
                        phase_next     = sts.tracks_last ? PH_IDLE : PH_LEN_HI;
                    end
                    else if (!track_is_raw_reg)
                    begin
                        phase_next = PH_TOKEN;
                    end
                    if (cmd.marker_run && sts.word_zero)
                    begin
                        // zero count writes nothing
                        cmd.emit      = done;
                        cmd.emit_kind = KIND_DONE;
                        cmd.emit_last = 1'b1;
                    end
                    else
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_RUN;
                        cmd.emit_last = done;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            header_index_reg <= 4'd0;
            track_is_raw_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            track_is_raw_reg <= track_is_raw_next;
        end
    end

endmodule

// File: src/msa_rle_dp.sv
// Datapath: header latches, capacity product, track counters, output register.
// Depends on msa_rle_pkg; controlled by msa_rle_ctrl.
module msa_rle_dp
    import msa_rle_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_ready,
    input  logic [7:0]        in_byte,
    input  cmd_t              cmd,
    output status_t           sts,
    output logic              out_valid,
    output kind_t             kind,
    output logic [7:0]        run_value,
    output logic [LEN_W-1:0]  run_length,
    output logic [POS_W-1:0]  out_position,
    output logic              last
);

    localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
    localparam int RAW_W  = 8 + SB_W;
    localparam int PROD_W = RAW_W + 8;
    localparam int CAPP_W = PROD_W + 16;

    logic [7:0]        run_byte_reg;
    logic [7:0]        count_high_reg;
    logic [RAW_W-1:0]  raw_len_reg;
    logic [7:0]        side_reg;
    logic [15:0]       tracks_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [POS_W-1:0]  cap_reg;
    logic [23:0]       tracks_left_reg;
    logic [15:0]       bytes_left_reg;
    logic [POS_W-1:0]  wpos_reg;

    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [7:0]        value_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;

    logic [15:0]       word;
    logic [LEN_W-1:0]  run_len;
    logic [7:0]        run_val;
    logic [POS_W:0]    run_end;
    logic [CAPP_W-1:0] cap_full;

    assign word     = {count_high_reg, in_byte};
    assign run_len  = cmd.marker_run ? word : LEN_W'(1);
    assign run_val  = cmd.marker_run ? run_byte_reg : in_byte;
    assign run_end  = {1'b0, wpos_reg} + (POS_W + 1)'(run_len);
    assign cap_full = CAPP_W'(prod_reg) * CAPP_W'(tracks_reg);

    always_comb
    begin
        sts.sig_ok      = (run_byte_reg == SIG_BYTE0) && (in_byte == SIG_BYTE1);
        sts.is_mark     = (in_byte == MARK_BYTE);
        sts.word_zero   = (word == 16'd0);
        sts.word_raw    = (RAW_W'(word) == raw_len_reg);
        sts.overflow    = (run_end > {1'b0, cap_reg});
        sts.bytes_last  = (bytes_left_reg == 16'd1);
        sts.bytes_short = (bytes_left_reg < 16'd4);
        sts.tracks_last = (tracks_left_reg == 24'd1);
        sts.tracks_zero = (tracks_left_reg == 24'd0);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lat_run_byte)
            run_byte_reg <= in_byte;
        if (cmd.lat_count_high)
            count_high_reg <= in_byte;
        if (cmd.lat_spt)
            raw_len_reg <= RAW_W'(in_byte) * RAW_W'(SECTOR_BYTES);
        if (cmd.lat_side)
            side_reg <= in_byte + 8'd1;
        if (cmd.lat_tracks)
        begin
            tracks_reg <= word + 16'd1;
            wpos_reg   <= '0;
        end
        else if (cmd.advance_pos)
        begin
            wpos_reg <= run_end[POS_W-1:0];
        end
        if (cmd.cap_step1)
        begin
            prod_reg        <= PROD_W'(raw_len_reg) * PROD_W'(side_reg);
            tracks_left_reg <= 24'(tracks_reg) * 24'(side_reg);
        end
        else if (cmd.dec_tracks)
        begin
            tracks_left_reg <= tracks_left_reg - 24'd1;
        end
        if (cmd.cap_step2)
            cap_reg <= (cap_full[CAPP_W-1:POS_W] != '0) ? '1 : cap_full[POS_W-1:0];
        if (cmd.load_bytes)
            bytes_left_reg <= word;
        else if (cmd.dec_bytes)
            bytes_left_reg <= bytes_left_reg - 16'd1;

        if (cmd.emit)
        begin
            kind_reg   <= cmd.emit_kind;
            last_reg   <= cmd.emit_last;
            value_reg  <= (cmd.emit_kind == KIND_RUN) ? run_val : 8'd0;
            length_reg <= (cmd.emit_kind == KIND_RUN) ? run_len : '0;
            pos_reg    <= (cmd.emit_kind == KIND_BADSIG) ? '0 : wpos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= cmd.emit || (out_valid_reg && !out_ready);
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign run_value    = value_reg;
    assign run_length   = length_reg;
    assign out_position = pos_reg;
    assign last         = last_reg;

endmodule

// File: src/msa_disk_image_rle_decoder_core.sv
// Timing: a result sits in the output register the cycle after its byte transfers;
// the completion after a header with no tracks shows up after the two capacity steps
// (PH_CAP1, PH_CAP2). Throughput: one byte per cycle while the output side drains
// and the parser is not busy; in_ready is low during the two multiply steps after the last header byte.
// Reset: rst_n (async, low) returns the parser to idle and empties the output.
// Depends on msa_rle_pkg, msa_rle_ctrl and msa_rle_dp.
module msa_disk_image_rle_decoder_core
    import msa_rle_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              start_of_file,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [7:0]        run_value,
    output logic [LEN_W-1:0]  run_length,
    output logic [POS_W-1:0]  out_position,
    output logic              last
);

    // The controller walks header, track length and token phases; every
    // decision it takes uses status flags formed in the datapath from the
    // current input byte and the stored counters. A transfer on the input
    // happens only when the output register is free or being emptied, so any
    // byte may produce a result without a second holding stage.

    cmd_t    cmd;
    status_t sts;
    kind_t   kind_int;

    msa_rle_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .start_of_file (start_of_file),
        .sts           (sts),
        .in_ready      (in_ready),
        .cmd           (cmd)
    );

    // Datapath holds the capacity (saturated at 2^33-1), the write position,
    // the remaining track and byte counts, and the output register.
    msa_rle_dp #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .out_ready    (out_ready),
        .in_byte      (in_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .kind         (kind_int),
        .run_value    (run_value),
        .run_length   (run_length),
        .out_position (out_position),
        .last         (last)
    );

    assign kind = kind_int;

endmodule

// File: src/msa_rle_checker.sv
// Port-level checks for the run-length image decoder, bound to the top level.
// Depends on msa_rle_pkg and msa_disk_image_rle_decoder_core.
module msa_rle_checker
    import msa_rle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        kind,
    input logic [7:0]        run_value,
    input logic [LEN_W-1:0]  run_length,
    input logic [POS_W-1:0]  out_position,
    input logic              last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_position)
            && $stable(run_length) && $stable(last))
        else $error("result changed while stalled");

    // status records always close the image and carry no run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_RUN) |-> last && (run_length == '0) && (run_value == 8'd0))
        else $error("status record malformed");

    a_badsig_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BADSIG) |-> (out_position == '0))
        else $error("bad signature with nonzero position");

    // zero-count markers never produce a run record
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_RUN) |-> (run_length != '0))
        else $error("empty data run");

endmodule

bind msa_disk_image_rle_decoder_core msa_rle_checker u_msa_rle_checker (.*);

// File: test/tb_msa_disk_image_rle_decoder_core.sv
// Testbench for msa_disk_image_rle_decoder_core: compressed image bytes in, run records out.
// Self-checking against a built-in decoder model; needs msa_rle_pkg and the core RTL only.
module tb_msa_disk_image_rle_decoder_core;
    import msa_rle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Byte offsets inside the 10-byte image header that the decoder looks at
    localparam logic [3:0] HDR_SIG0   = 4'd0;
    localparam logic [3:0] HDR_SIG1   = 4'd1;
    localparam logic [3:0] HDR_SPT    = 4'd3;
    localparam logic [3:0] HDR_SIDES  = 4'd5;
    localparam logic [3:0] HDR_END_HI = 4'd8;
    localparam logic [3:0] HDR_END_LO = 4'd9;

    localparam logic [63:0] CAP_LIMIT  = 64'h1_FFFF_FFFF;
    localparam int          RANDOM_LEN = 1600;
    localparam int          HOLD_CYCLES = 300;

    typedef enum logic [3:0] {
        ST_IDLE, ST_HEADER, ST_LEN_HI, ST_LEN_LO, ST_RAW,
        ST_TOKEN, ST_MVAL, ST_CNT_HI, ST_CNT_LO
    } parse_st_t;

    typedef struct packed {
        logic       sof;
        logic [7:0] value;
    } feed_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         value;
        logic [LEN_W-1:0]   length;
        logic [POS_W-1:0]   pos;
        logic               last;
    } run_rec_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              start_of_file = 1'b0;
    logic [7:0]        in_byte = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        kind;
    logic [7:0]        run_value;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-1:0]  out_position;
    logic              last;

    msa_disk_image_rle_decoder_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_of_file(start_of_file),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .run_value    (run_value),
        .run_length   (run_length),
        .out_position (out_position),
        .last         (last)
    );

    always #4 clk = ~clk;

    feed_item_t byte_feed[$];       // bytes still to be offered, in file order
    run_rec_t   expected_runs[$];   // records predicted but not yet seen
    int         total_items = 0;
    int         bytes_taken = 0;
    int         mismatches = 0;
    int         raw_budget = 3;     // raw tracks are 512 bytes each; keep the run short
    int         tx_idle_pct;
    int         rx_idle_pct;
    logic       rx_hold = 1'b0;

    // ------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------
    parse_st_t   dec_phase = ST_IDLE;
    logic [3:0]  dec_hdr_idx = '0;
    logic [7:0]  dec_spt = '0;
    logic [7:0]  dec_sides = '0;
    logic [15:0] dec_tracks = '0;
    logic [33:0] dec_cap = '0;
    logic [23:0] dec_tracks_left = '0;
    logic [15:0] dec_bytes_left = '0;
    logic        dec_raw = 1'b0;
    logic [7:0]  dec_hold = '0;     // signature byte 0, then the marker's run value
    logic [7:0]  dec_hi = '0;       // high byte of whichever word is being assembled
    logic [33:0] dec_wpos = '0;

    // Error or bad signature: ends the image, parser goes idle
    function automatic bit abort_image(output run_rec_t r, input kind_t k);
        dec_phase = ST_IDLE;
        r.kind   = k;
        r.value  = '0;
        r.length = '0;
        r.pos    = (k == KIND_BADSIG) ? '0 : dec_wpos[POS_W-1:0];
        r.last   = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit close_image(output run_rec_t r);
        dec_phase = ST_IDLE;
        r.kind   = KIND_DONE;
        r.value  = '0;
        r.length = '0;
        r.pos    = dec_wpos[POS_W-1:0];
        r.last   = 1'b1;
        return 1'b1;
    endfunction

    // Returns 1 when the track just finished was the last of the image
    function automatic bit end_track();
        if (dec_tracks_left != 0)
            dec_tracks_left = dec_tracks_left - 24'd1;
        if (dec_tracks_left == 0)
        begin
            dec_phase = ST_IDLE;
            return 1'b1;
        end
        dec_phase = ST_LEN_HI;
        return 1'b0;
    endfunction

    function automatic bit write_run(output run_rec_t r, input logic [7:0] v,
                                     input logic [15:0] n);
        logic [34:0] stop;
        logic [33:0] at;
        bit          done;
        r    = '0;
        at   = dec_wpos;
        stop = 35'(dec_wpos) + 35'(n);
        if (stop > 35'(dec_cap))
            return abort_image(r, KIND_ERROR);
        dec_wpos = stop[33:0];
        done = 1'b0;
        if (dec_bytes_left == 0)
            done = end_track();
        else if (!dec_raw)
            dec_phase = ST_TOKEN;
        // zero-count marker writes nothing
        if (n == 0)
            return done ? close_image(r) : 1'b0;
        r.kind   = KIND_RUN;
        r.value  = v;
        r.length = n;
        r.pos    = at[POS_W-1:0];
        r.last   = done;
        return 1'b1;
    endfunction

    // One accepted byte; returns 1 with the record when the byte yields one
    function automatic bit predict_run(input logic sof, input logic [7:0] b,
                                       output run_rec_t r);
        logic [63:0] prod;
        logic [15:0] len;
        r = '0;
        if (sof)
        begin
            dec_phase       = ST_HEADER;
            dec_hdr_idx     = '0;
            dec_spt         = '0;
            dec_sides       = '0;
            dec_tracks      = '0;
            dec_cap         = '0;
            dec_tracks_left = '0;
            dec_bytes_left  = '0;
            dec_raw         = 1'b0;
            dec_hold        = '0;
            dec_hi          = '0;
            dec_wpos        = '0;
        end
        case (dec_phase)
            ST_HEADER:
            begin
                case (dec_hdr_idx)
                    HDR_SIG0:   dec_hold = b;
                    HDR_SIG1:
                        if (dec_hold != SIG_BYTE0 || b != SIG_BYTE1)
                            return abort_image(r, KIND_BADSIG);
                    HDR_SPT:    dec_spt = b;
                    HDR_SIDES:  dec_sides = b + 8'd1;
                    HDR_END_HI: dec_hi = b;
                    HDR_END_LO:
                    begin
                        dec_tracks = {dec_hi, b} + 16'd1;
                        prod = 64'(dec_spt) * 64'(SECTOR_BYTES_DEF) * 64'(dec_sides)
                               * 64'(dec_tracks);
                        dec_cap = (prod > CAP_LIMIT) ? CAP_LIMIT[33:0] : prod[33:0];
                        dec_tracks_left = 24'(32'(dec_tracks) * 32'(dec_sides));
                        dec_wpos = '0;
                        if (dec_tracks_left == 0)
                            return close_image(r);
                        dec_phase = ST_LEN_HI;
                        return 1'b0;
                    end
                    default: ;
                endcase
                dec_hdr_idx = dec_hdr_idx + 4'd1;
                return 1'b0;
            end
            ST_LEN_HI:
            begin
                dec_hi    = b;
                dec_phase = ST_LEN_LO;
                return 1'b0;
            end
            ST_LEN_LO:
            begin
                len = {dec_hi, b};
                dec_bytes_left = len;
                dec_raw = (32'(len) == 32'(dec_spt) * 32'(SECTOR_BYTES_DEF));
                if (len == 0)
                    return end_track() ? close_image(r) : 1'b0;
                dec_phase = dec_raw ? ST_RAW : ST_TOKEN;
                return 1'b0;
            end
            ST_RAW:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                return write_run(r, b, 16'd1);
            end
            ST_TOKEN:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                if (b != MARK_BYTE)
                    return write_run(r, b, 16'd1);
                // marker needs value and count inside the same track
                if (dec_bytes_left < 16'd3)
                    return abort_image(r, KIND_ERROR);
                dec_phase = ST_MVAL;
                return 1'b0;
            end
            ST_MVAL:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                dec_hold  = b;
                dec_phase = ST_CNT_HI;
                return 1'b0;
            end
            ST_CNT_HI:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                dec_hi    = b;
                dec_phase = ST_CNT_LO;
                return 1'b0;
            end
            ST_CNT_LO:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                return write_run(r, dec_hold, {dec_hi, b});
            end
            default:
            begin
                dec_phase = ST_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders: append bytes to byte_feed
    // ------------------------------------------------------------------
    task automatic feed(input logic sof, input logic [7:0] v);
        feed_item_t it;
        it.sof   = sof;
        it.value = v;
        byte_feed.push_back(it);
    endtask

    task automatic feed_word(input logic [15:0] w);
        feed(1'b0, w[15:8]);
        feed(1'b0, w[7:0]);
    endtask

    // High bytes of the first words and the start-track word are don't-care
    task automatic feed_header(input logic [7:0] spt, input logic [7:0] sides_lo,
                               input logic [15:0] end_trk);
        feed(1'b1, SIG_BYTE0);
        feed(1'b0, SIG_BYTE1);
        feed(1'b0, 8'($urandom));
        feed(1'b0, spt);
        feed(1'b0, 8'($urandom));
        feed(1'b0, sides_lo);
        feed_word(16'($urandom));
        feed_word(end_trk);
    endtask

    // Coded track body of exactly n bytes; room tracks capacity left so that
    // most runs fit and a few overflow
    task automatic feed_coded_track(input int n, inout longint room);
        int         left;
        int         cnt;
        int         hi;
        logic [7:0] lit;
        left = n;
        while (left > 0)
        begin
            if (left < 4 && $urandom_range(15) == 0)
            begin
                // marker cut off by the end of its track
                feed(1'b0, MARK_BYTE);
                repeat (left - 1) feed(1'b0, 8'($urandom));
                left = 0;
            end
            else if (left >= 4 && $urandom_range(2) == 0)
            begin
                hi = (room > 200) ? 200 : ((room < 1) ? 1 : int'(room));
                case ($urandom_range(15))
                    0:       cnt = 0;
                    1:       cnt = $urandom_range(65535);
                    default: cnt = $urandom_range(hi, 1);
                endcase
                feed(1'b0, MARK_BYTE);
                feed(1'b0, 8'($urandom));
                feed_word(16'(cnt));
                room -= cnt;
                left -= 4;
            end
            else
            begin
                do lit = 8'($urandom); while (lit == MARK_BYTE);
                feed(1'b0, lit);
                room -= 1;
                left -= 1;
            end
        end
    endtask

    // Small well-formed image: 1..6 tracks, mostly coded, now and then raw or empty
    task automatic feed_good_image();
        logic [7:0]  spt;
        logic [7:0]  sides_lo;
        logic [15:0] end_trk;
        longint      room;
        int          ntracks;
        int          n;
        case ($urandom_range(9))
            0:       spt = 8'd0;
            7, 8:    spt = 8'd2;
            9:       spt = 8'($urandom_range(255, 3));
            default: spt = 8'd1;
        endcase
        sides_lo = 8'($urandom_range(1));
        end_trk  = 16'($urandom_range(2));
        ntracks  = (int'(end_trk) + 1) * (int'(sides_lo) + 1);
        room     = longint'(spt) * SECTOR_BYTES_DEF * ntracks;
        feed_header(spt, sides_lo, end_trk);
        repeat (ntracks)
        begin
            if (spt == 8'd1 && raw_budget > 0 && $urandom_range(4) == 0)
            begin
                raw_budget--;
                feed_word(16'(SECTOR_BYTES_DEF));
                repeat (SECTOR_BYTES_DEF) feed(1'b0, 8'($urandom));
                room -= SECTOR_BYTES_DEF;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    n = 0;
                else
                    n = $urandom_range(($urandom_range(3) == 0) ? 60 : 16, 1);
                feed_word(16'(n));
                feed_coded_track(n, room);
            end
        end
    endtask

    // Capacity product saturates; a few long runs, then abandoned by the next image
    task automatic feed_huge_image();
        int n;
        feed_header(8'hFF, 8'hFE, 16'hFFFE);
        repeat ($urandom_range(3, 1))
        begin
            n = 4 * $urandom_range(4, 1);
            feed_word(16'(n));
            repeat (n / 4)
            begin
                feed(1'b0, MARK_BYTE);
                feed(1'b0, 8'($urandom));
                feed_word(16'hFFFF);
            end
        end
    endtask

    task automatic feed_broken();
        logic [7:0] v;
        case ($urandom_range(3))
            0:
            begin
                // zero tracks or zero sides: completion right after the header
                if ($urandom_range(1))
                    feed_header(8'($urandom), 8'hFF, 16'($urandom));
                else
                    feed_header(8'($urandom), 8'($urandom), 16'hFFFF);
            end
            1:
            begin
                // bad signature, either byte wrong
                if ($urandom_range(1))
                begin
                    feed(1'b1, SIG_BYTE0);
                    do v = 8'($urandom); while (v == SIG_BYTE1);
                    feed(1'b0, v);
                end
                else
                begin
                    do v = 8'($urandom); while (v == SIG_BYTE0);
                    feed(1'b1, v);
                    feed(1'b0, SIG_BYTE1);
                end
            end
            2:
            begin
                // image cut short, restarted by whatever follows
                feed_header(8'd1, 8'd0, 16'd0);
                repeat ($urandom_range(12)) feed(1'b0, 8'($urandom));
            end
            default:
            begin
                if ($urandom_range(1))
                    feed(1'b1, 8'($urandom));
                repeat ($urandom_range(3, 1)) feed(1'b0, 8'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Idle mix: sender-light / receiver-heavy, then the reverse, then none
    // ------------------------------------------------------------------
    always_comb
    begin
        if (bytes_taken < total_items / 3)
        begin
            tx_idle_pct = 32;
            rx_idle_pct = 67;
        end
        else if (bytes_taken < 2 * total_items / 3)
        begin
            tx_idle_pct = 67;
            rx_idle_pct = 32;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // Driver: a new byte goes up only when the previous transfer completed
    // or nothing was offered; valid is never pulled back before a transfer.
    always @(posedge clk)
    begin
        feed_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = byte_feed.pop_front();
                in_valid      <= 1'b1;
                start_of_file <= nxt.sof;
                in_byte       <= nxt.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure; rx_hold forces a long stall
    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver stall late in the run, while the sender keeps offering
    // bytes: the output register fills and in_ready must drop.
    initial
    begin
        wait (total_items > 0 && bytes_taken >= total_items * 3 / 4);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Monitor: predicts on every input transfer, then checks any output
    // transfer of the same edge against the oldest prediction.
    always @(posedge clk)
    begin
        run_rec_t pred;
        run_rec_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                bytes_taken <= bytes_taken + 1;
                if (predict_run(start_of_file, in_byte, pred))
                    expected_runs.push_back(pred);
            end
            if (out_valid && out_ready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("unexpected record: kind %0d pos 0x%0h", kind, out_position);
                    mismatches++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    check_field("kind", 64'(want.kind), 64'(kind));
                    check_field("run_value", 64'(want.value), 64'(run_value));
                    check_field("run_length", 64'(want.length), 64'(run_length));
                    check_field("out_position", 64'(want.pos), 64'(out_position));
                    check_field("last", 64'(want.last), 64'(last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        int goal;
        int pick;

        // Directed: stray byte while idle, both bad-signature forms, a header
        // abandoned by a restart, then one image that fills its capacity
        // exactly with literals, a zero-count marker and a 0xE5-valued run.
        feed(1'b0, 8'h00);
        feed(1'b1, SIG_BYTE0);
        feed(1'b0, 8'hF0);
        feed(1'b1, 8'hFF);
        feed(1'b0, SIG_BYTE1);
        feed(1'b1, SIG_BYTE0);
        feed_header(8'd1, 8'd0, 16'd0);
        feed_word(16'd10);
        feed(1'b0, 8'hFF);
        feed(1'b0, 8'h00);
        feed(1'b0, MARK_BYTE);
        feed(1'b0, 8'h5A);
        feed_word(16'd0);
        feed(1'b0, MARK_BYTE);
        feed(1'b0, MARK_BYTE);
        feed_word(16'd510);

        // Random: mostly well-formed images, the rest corner and broken cases
        goal = byte_feed.size() + RANDOM_LEN;
        while (byte_feed.size() < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                feed_good_image();
            else if (pick < 73)
                feed_huge_image();
            else
                feed_broken();
        end
        total_items = byte_feed.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || in_valid) @(negedge clk);
        while (expected_runs.size() != 0) @(negedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("** msa_disk_image_rle_decoder_core: PASSED **");
        else
            $display("** msa_disk_image_rle_decoder_core: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("** msa_disk_image_rle_decoder_core: FAILED **");
        $finish;
    end

endmodule
